@@ src/elb_pkg.sv @@
// Shared types and constants for the learning bridge.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none

package elb_pkg;

    // Table and port geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int PORT_W        = 4;
    localparam int MASK_W        = 16;
    localparam int MAC_W         = 48;
    localparam int ENTRY_W       = MAC_W + PORT_W;

    // Multicast flag position inside a MAC address.
    localparam int MCAST_BIT = 40;

    // Membership bits that take effect.
    localparam logic [MASK_W-1:0] MEMBER_VALID = MASK_W'((17'(1) << PORT_COUNT) - 17'(1));

    // Result status codes.
    typedef enum logic [2:0] {
        ST_FORWARD    = 3'd0,
        ST_FLOOD      = 3'd1,
        ST_NOT_MEMBER = 3'd2,
        ST_BAD_SOURCE = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_UNKNOWN    = 3'd5
    } t_status;

    // Packet kinds.
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] in_port;
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
    } t_item;

    // Output transaction payload.
    typedef struct packed {
        logic [MASK_W-1:0] out_mask;
        logic [2:0]        status;
    } t_result;

    // Which result the datapath builds.
    typedef enum logic [2:0] {
        RES_NOT_MEMBER,
        RES_BAD_SOURCE,
        RES_TABLE_FULL,
        RES_TX_FLOOD,
        RES_LOOKUP
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scan_start;
        logic     key_dst;
        logic     write;
        logic     res_load;
        t_res_sel res_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic dst_mcast;
        logic port_member;
        logic src_bad;
        logic scan_done;
        logic hit;
        logic free_found;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ src/elb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`default_nettype none

module elb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/elb_ctrl.sv @@
// Controller state machine for the learning bridge.
// Depends on elb_pkg for command and status types.
`default_nettype none

module elb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire elb_pkg::t_stat i_stat,
    output elb_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEARN,
        S_WRITE,
        S_LOOK,
        S_RESULT
    } t_state;

    t_state            r_state;
    elb_pkg::t_res_sel r_res_sel;

    // State register and registered result selection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_sel <= elb_pkg::RES_LOOKUP;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_stat.kind == elb_pkg::KIND_TX) begin
                        if (i_stat.dst_mcast) begin
                            r_res_sel <= elb_pkg::RES_TX_FLOOD;
                            r_state   <= S_RESULT;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end else if (!i_stat.port_member) begin
                        r_res_sel <= elb_pkg::RES_NOT_MEMBER;
                        r_state   <= S_RESULT;
                    end else if (i_stat.src_bad) begin
                        r_res_sel <= elb_pkg::RES_BAD_SOURCE;
                        r_state   <= S_RESULT;
                    end else begin
                        r_state <= S_LEARN;
                    end
                end
                S_LEARN: begin
                    if (i_stat.scan_done) begin
                        if (!i_stat.hit && !i_stat.free_found) begin
                            r_res_sel <= elb_pkg::RES_TABLE_FULL;
                            r_state   <= S_RESULT;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (i_stat.scan_done) begin
                        r_res_sel <= elb_pkg::RES_LOOKUP;
                        r_state   <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_sel    = r_res_sel;
        o_cmd.load       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.write      = (r_state == S_WRITE);
        o_cmd.res_load   = (r_state == S_RESULT) && i_stat.out_free;
        // Source search starts after the checks; destination search after
        // the learn write, or straight from the checks for a transmit.
        if (r_state == S_CHECK) begin
            o_cmd.scan_start = (i_stat.kind == elb_pkg::KIND_TX) ? !i_stat.dst_mcast
                             : (i_stat.port_member && !i_stat.src_bad);
            o_cmd.key_dst    = (i_stat.kind == elb_pkg::KIND_TX);
        end else if (r_state == S_WRITE) begin
            o_cmd.scan_start = 1'b1;
            o_cmd.key_dst    = 1'b1;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ src/elb_datapath.sv @@
// Datapath of the learning bridge: item and config registers, table
// storage, sequential search engine and result register. Uses elb_pkg, elb_ram.
`default_nettype none

module elb_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [elb_pkg::MASK_W-1:0] i_cfg_wdata,
    input  wire elb_pkg::t_item             i_in_item,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output elb_pkg::t_result                o_out_item,
    input  wire elb_pkg::t_cmd              i_cmd,
    output elb_pkg::t_stat                  o_stat
);

    logic [elb_pkg::MASK_W-1:0]   r_member_mask;
    elb_pkg::t_item               r_item;
    logic                         r_key_dst;
    logic                         r_scan_act;
    logic [elb_pkg::CNT_W-1:0]    r_idx;
    logic                         r_pipe_vld;
    logic [elb_pkg::IDX_W-1:0]    r_pipe_idx;
    logic                         r_hit;
    logic                         r_end;
    logic [elb_pkg::IDX_W-1:0]    r_hit_idx;
    logic [elb_pkg::PORT_W-1:0]   r_hit_port;
    logic                         r_free_found;
    logic [elb_pkg::IDX_W-1:0]    r_free_idx;
    logic                         r_entry_valid [elb_pkg::TABLE_ENTRIES];
    logic                         r_out_valid;
    elb_pkg::t_result             r_out_item;
    elb_pkg::t_result             n_out_item;

    logic [elb_pkg::MASK_W-1:0]   members;
    logic [elb_pkg::MASK_W-1:0]   in_bit;
    logic [elb_pkg::MASK_W-1:0]   hit_bit;
    logic [elb_pkg::MAC_W-1:0]    key;
    logic                         issue;
    logic                         scan_done;
    logic [elb_pkg::IDX_W-1:0]    wr_idx;
    logic [elb_pkg::ENTRY_W-1:0]  rd_data;
    logic                         entry_match;

    assign members = r_member_mask & elb_pkg::MEMBER_VALID;
    assign in_bit  = elb_pkg::MASK_W'(1) << r_item.in_port;
    assign hit_bit = elb_pkg::MASK_W'(1) << r_hit_port;
    assign key     = r_key_dst ? r_item.dst_mac : r_item.src_mac;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member_mask <= '0;
        end else if (i_cfg_we) begin
            r_member_mask <= i_cfg_wdata;
        end
    end

    // Captured item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    // Table storage: address and port per entry.
    assign issue  = r_scan_act && !r_hit && (r_idx != elb_pkg::CNT_W'(elb_pkg::TABLE_ENTRIES));
    assign wr_idx = r_hit ? r_hit_idx : r_free_idx;

    elb_ram #(
        .WIDTH (elb_pkg::ENTRY_W),
        .DEPTH (elb_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (wr_idx),
        .i_wdata ({r_item.src_mac, r_item.in_port}),
        .i_re    (issue),
        .i_raddr (r_idx[elb_pkg::IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign entry_match = r_entry_valid[r_pipe_idx]
                      && (rd_data[elb_pkg::ENTRY_W-1:elb_pkg::PORT_W] == key);
    assign scan_done   = r_hit || r_end;

    // Entry valid bits, set by a learn write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < elb_pkg::TABLE_ENTRIES; i++) begin
                r_entry_valid[i] <= 1'b0;
            end
        end else if (i_cmd.write) begin
            r_entry_valid[wr_idx] <= 1'b1;
        end
    end

    // Search engine: one read issued and one entry compared per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act   <= 1'b0;
            r_idx        <= '0;
            r_pipe_vld   <= 1'b0;
            r_hit        <= 1'b0;
            r_end        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_act   <= 1'b1;
            r_key_dst    <= i_cmd.key_dst;
            r_idx        <= '0;
            r_pipe_vld   <= 1'b0;
            r_hit        <= 1'b0;
            r_end        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_pipe_vld <= issue;
            if (issue) begin
                r_pipe_idx <= r_idx[elb_pkg::IDX_W-1:0];
                r_idx      <= r_idx + elb_pkg::CNT_W'(1);
            end
            if (r_pipe_vld && !r_hit) begin
                if (entry_match) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_pipe_idx;
                    r_hit_port <= rd_data[elb_pkg::PORT_W-1:0];
                end
                if (!r_entry_valid[r_pipe_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pipe_idx;
                end
                if (r_pipe_idx == elb_pkg::IDX_W'(elb_pkg::TABLE_ENTRIES - 1)) begin
                    r_end <= 1'b1;
                end
            end
            if (scan_done) begin
                r_scan_act <= 1'b0;
            end
        end
    end

    // Result formation.
    always_comb begin
        n_out_item = '0;
        case (i_cmd.res_sel)
            elb_pkg::RES_NOT_MEMBER: begin
                n_out_item.status = elb_pkg::ST_NOT_MEMBER;
            end
            elb_pkg::RES_BAD_SOURCE: begin
                n_out_item.status = elb_pkg::ST_BAD_SOURCE;
            end
            elb_pkg::RES_TABLE_FULL: begin
                n_out_item.status = elb_pkg::ST_TABLE_FULL;
            end
            elb_pkg::RES_TX_FLOOD: begin
                n_out_item.out_mask = members;
                n_out_item.status   = elb_pkg::ST_FLOOD;
            end
            elb_pkg::RES_LOOKUP: begin
                if (r_hit) begin
                    // A hit on a port that is no longer a member is stale.
                    if ((hit_bit & members) == '0) begin
                        n_out_item.status = elb_pkg::ST_UNKNOWN;
                    end else begin
                        n_out_item.out_mask = hit_bit;
                        n_out_item.status   = elb_pkg::ST_FORWARD;
                    end
                end else if (r_item.kind == elb_pkg::KIND_TX) begin
                    n_out_item.out_mask = members;
                    n_out_item.status   = elb_pkg::ST_FLOOD;
                end else if (r_item.dst_mac[elb_pkg::MCAST_BIT]) begin
                    n_out_item.out_mask = members & ~in_bit;
                    n_out_item.status   = elb_pkg::ST_FLOOD;
                end else begin
                    n_out_item.status = elb_pkg::ST_UNKNOWN;
                end
            end
            default: begin
                n_out_item.status = elb_pkg::ST_UNKNOWN;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Status for the controller.
    always_comb begin
        o_stat             = '0;
        o_stat.kind        = r_item.kind;
        o_stat.dst_mcast   = r_item.dst_mac[elb_pkg::MCAST_BIT];
        o_stat.port_member = ({1'b0, r_item.in_port} < 5'(elb_pkg::PORT_COUNT))
                          && ((members & in_bit) != '0);
        o_stat.src_bad     = r_item.src_mac[elb_pkg::MCAST_BIT] || (r_item.src_mac == '0);
        o_stat.scan_done   = scan_done;
        o_stat.hit         = r_hit;
        o_stat.free_found  = r_free_found;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

@@ src/ethernet_learning_bridge_unit.sv @@
// Top level of the learning Ethernet bridge.
// Instantiates elb_ctrl and elb_datapath; types come from elb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one packet
//   descriptor per transaction: kind, ingress port, source and destination MAC.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly one
//   result per packet: the egress port mask and a status code.
//   Config: i_cfg_we writes i_cfg_wdata into the port membership mask.
//   Sequence: a received packet passes the checks, a source search of the
//   table, the learn write, a destination search and the result load; a
//   transmit goes from the checks to the destination search, or straight to
//   the result if multicast. A search reads the entries in turn and ends at
//   the last one or early on a hit; packets rejected by the checks skip it.
//   One packet is processed at a time; the next one is accepted once the
//   result sits in the output register, even if it has not yet been taken.
//   Reset clears the membership mask and both channels and invalidates all table entries.
//   While the receiver stalls, the result holds in the output register and
//   the block waits before loading the next result.
`default_nettype none

module ethernet_learning_bridge_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [elb_pkg::MASK_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire elb_pkg::t_item             i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output elb_pkg::t_result                o_out_item
);

    elb_pkg::t_cmd  cmd;
    elb_pkg::t_stat stat;

    // Sequencing of checks, learn and lookup.
    elb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Table, search engine and result register.
    elb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire
